// ----- hw/rtl/cfve_pkg.sv -----
`timescale 1ns / 1ps

package cfve_pkg;

    // CORDIC rotation count; valid range 12 to 32
    localparam int CORDIC_STAGES = 24;

    // Restoring steps of the mod 2*pi reduction: |phase| <= 2^63 < (2*pi)<<22
    localparam int MOD_STEPS = 22;

    // Abs stage, mod cells, fixup, fold, rotations, clamp
    localparam int SC_LAT = MOD_STEPS + CORDIC_STAGES + 4;

    // Phase product stage plus sincos plus six product stages
    localparam int LAT = SC_LAT + 7;

    localparam logic [63:0] TWO_PI_Q40  = 64'h0000_0648_7ED5_110B;
    localparam logic [63:0] PI_Q40      = TWO_PI_Q40 >> 1;
    localparam logic [63:0] HALF_PI_Q40 = TWO_PI_Q40 >> 2;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sh0_26DD_3B6A;
    localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;

    // Register indexes of the write port
    localparam logic [1:0] REG_AMPLITUDE  = 2'd0;
    localparam logic [1:0] REG_MOD_DEPTH  = 2'd1;
    localparam logic [1:0] REG_TIME_RATE  = 2'd2;
    localparam logic [1:0] REG_SPACE_RATE = 2'd3;

    typedef struct packed {
        logic [31:0]        sample_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } cfve_in_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] dvx_dt;
        logic signed [31:0] dvx_dx;
        logic signed [31:0] dvx_dy;
        logic signed [31:0] dvy_dt;
        logic signed [31:0] dvy_dx;
        logic signed [31:0] dvy_dy;
    } cfve_out_t;

    // Data carried along the reduction cells
    typedef struct packed {
        logic [63:0] rem;
        logic        neg;
    } cfve_mod_t;

    // Data carried along the rotation cells
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [43:0] r;
        logic               flip;
    } cfve_rot_t;

    // Shift-subtract quotient, used only on constants
    function automatic logic [63:0] udiv_const(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q40 by the alternating series, summed in Q62
    function automatic logic signed [43:0] atan_q40(input int i);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int                 e;
        sum = '0;
        if (i == 0) begin
            return 44'(TWO_PI_Q40 >> 3);
        end
        for (int k = 0; k < 63; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0) begin
                term = $signed(udiv_const(64'd1 << e, 64'(2 * k + 1)));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return 44'((sum + 64'sd2097152) >>> 22);
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        if (v == 32'sh8000_0000) begin
            return 32'sh7FFF_FFFF;
        end
        return -v;
    endfunction

    // Product floored back by sh bits and saturated
    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input int unsigned sh);
        logic signed [63:0] p;
        p = a * b;
        return sat64(p >>> sh);
    endfunction

endpackage

// ----- hw/rtl/cellular_flow_velocity_eval.sv -----
`timescale 1ns / 1ps

// Throughput: one item per cycle; busy stays low, the pipeline never holds.
// The rate is set by the row of reduction and rotation cells, each one register deep.
// Each result comes with a one-cycle strobe and holds until the next; the receiver cannot stall.
// Reset clears the valid line and loads the register defaults; data is not cleared.
module cellular_flow_velocity_eval (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cfve_pkg::cfve_in_t   sample,
    input  logic                 wr_en,
    input  logic [1:0]           wr_index,
    input  logic [31:0]          wr_data,
    output logic                 strobe,
    output cfve_pkg::cfve_out_t  result
);
    import cfve_pkg::*;

    // Configuration registers
    logic signed [31:0] amplitude_reg;
    logic signed [31:0] mod_depth_reg;
    logic signed [31:0] time_rate_reg;
    logic signed [31:0] space_rate_reg;
    // U*k and U*k*w depend on the registers alone
    logic signed [31:0] uk_reg;
    logic signed [31:0] ukw_reg;

    // Valid line, one bit per pipeline stage
    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     vld_next;
    logic               accept;

    // Phase products
    logic signed [64:0] pt_full;
    logic signed [63:0] pt_reg;
    logic signed [63:0] px_reg;
    logic signed [63:0] py_reg;

    logic signed [31:0] st;
    logic signed [31:0] ct;
    logic signed [31:0] sx;
    logic signed [31:0] cx;
    logic signed [31:0] sy;
    logic signed [31:0] cy;

    // Stage A: k*sin(wt)
    logic signed [63:0] m1_reg;
    logic signed [31:0] a_ct_reg, a_sx_reg, a_cx_reg, a_sy_reg, a_cy_reg;
    // Stage B: g
    logic signed [31:0] g_reg;
    logic signed [31:0] b_ct_reg, b_sx_reg, b_cx_reg, b_sy_reg, b_cy_reg;
    // Stage C: U*g
    logic signed [31:0] ug_reg;
    logic signed [31:0] c_ct_reg, c_sx_reg, c_cx_reg, c_sy_reg, c_cy_reg;
    // Stage D: first factors of each chain
    logic signed [31:0] ugp_reg, ugs_reg, ugc_reg, kc_reg;
    logic signed [31:0] d_sx_reg, d_cx_reg, d_sy_reg, d_cy_reg;
    // Stage E: second factors
    logic signed [31:0] r0_reg, r1_reg, pc_reg, ps_reg, ks_reg, kx_reg;
    logic signed [31:0] e_sy_reg, e_cy_reg;
    cfve_out_t          result_next;
    logic signed [31:0] pcc;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign strobe = vld_reg[LAT-1];

    // Register writes; the port is to be used only while the pipeline is empty, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            amplitude_reg  <= 32'sd65536;
            mod_depth_reg  <= '0;
            time_rate_reg  <= '0;
            space_rate_reg <= 32'sd52707179;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_AMPLITUDE:  amplitude_reg  <= wr_data;
                REG_MOD_DEPTH:  mod_depth_reg  <= wr_data;
                REG_TIME_RATE:  time_rate_reg  <= wr_data;
                REG_SPACE_RATE: space_rate_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        uk_reg  <= fmul(amplitude_reg, mod_depth_reg, 16);
        ukw_reg <= fmul(uk_reg, time_rate_reg, 24);
    end

    // Advance the valid line every cycle
    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Time is unsigned: widen by a zero bit before the signed product
    assign pt_full = $signed({1'b0, sample.sample_time}) * time_rate_reg;

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_full[63:0];
        px_reg <= sample.pos_x * space_rate_reg;
        py_reg <= sample.pos_y * space_rate_reg;
    end

    // Three identical sine/cosine lanes, same depth so they stay aligned
    cfve_sincos u_sc_t (.clk(clk), .phase(pt_reg), .sin_q30(st), .cos_q30(ct));
    cfve_sincos u_sc_x (.clk(clk), .phase(px_reg), .sin_q30(sx), .cos_q30(cx));
    cfve_sincos u_sc_y (.clk(clk), .phase(py_reg), .sin_q30(sy), .cos_q30(cy));

    // Product chain: one multiplier deep per stage, factors left to right
    always_ff @(posedge clk)
    begin
        // A
        m1_reg   <= mod_depth_reg * st;
        a_ct_reg <= ct;
        a_sx_reg <= sx;
        a_cx_reg <= cx;
        a_sy_reg <= sy;
        a_cy_reg <= cy;
        // B
        g_reg    <= sat64(64'sd65536 + (m1_reg >>> 30));
        b_ct_reg <= a_ct_reg;
        b_sx_reg <= a_sx_reg;
        b_cx_reg <= a_cx_reg;
        b_sy_reg <= a_sy_reg;
        b_cy_reg <= a_cy_reg;
        // C
        ug_reg   <= fmul(amplitude_reg, g_reg, 16);
        c_ct_reg <= b_ct_reg;
        c_sx_reg <= b_sx_reg;
        c_cx_reg <= b_cx_reg;
        c_sy_reg <= b_sy_reg;
        c_cy_reg <= b_cy_reg;
        // D
        ugp_reg  <= fmul(ug_reg, space_rate_reg, 24);
        ugs_reg  <= fmul(ug_reg, c_sx_reg, 30);
        ugc_reg  <= fmul(ug_reg, c_cx_reg, 30);
        kc_reg   <= fmul(ukw_reg, c_ct_reg, 30);
        d_sx_reg <= c_sx_reg;
        d_cx_reg <= c_cx_reg;
        d_sy_reg <= c_sy_reg;
        d_cy_reg <= c_cy_reg;
        // E
        r0_reg   <= fmul(ugs_reg, d_cy_reg, 30);
        r1_reg   <= neg_sat(fmul(ugc_reg, d_sy_reg, 30));
        pc_reg   <= fmul(ugp_reg, d_cx_reg, 30);
        ps_reg   <= fmul(ugp_reg, d_sx_reg, 30);
        ks_reg   <= fmul(kc_reg, d_sx_reg, 30);
        kx_reg   <= fmul(kc_reg, d_cx_reg, 30);
        e_sy_reg <= d_sy_reg;
        e_cy_reg <= d_cy_reg;
    end

    // F: last factors and the saturating sign flips
    always_comb
    begin
        pcc                = fmul(pc_reg, e_cy_reg, 30);
        result_next.vel_x  = r0_reg;
        result_next.vel_y  = r1_reg;
        result_next.dvx_dt = fmul(ks_reg, e_cy_reg, 30);
        result_next.dvx_dx = pcc;
        result_next.dvx_dy = neg_sat(fmul(ps_reg, e_sy_reg, 30));
        result_next.dvy_dt = neg_sat(fmul(kx_reg, e_sy_reg, 30));
        result_next.dvy_dx = fmul(ps_reg, e_sy_reg, 30);
        result_next.dvy_dy = neg_sat(pcc);
    end

    // Hold the result between items
    always_ff @(posedge clk)
    begin
        if (vld_reg[LAT-2]) begin
            result <= result_next;
        end
    end

`ifndef SYNTH
    a_strobe_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(accept, LAT))
        else $error("result without a matching item");

    a_accept_gives_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT strobe)
        else $error("item lost in the pipeline");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[LAT-2] |=> $stable(result))
        else $error("result changed without an item");
`endif

endmodule

// ----- hw/rtl/cfve_mod_cell.sv -----
`timescale 1ns / 1ps

module cfve_mod_cell (
    input  logic                 clk,
    input  logic [64:0]          modulus,
    input  cfve_pkg::cfve_mod_t  d_in,
    output cfve_pkg::cfve_mod_t  d_out
);
    import cfve_pkg::*;

    cfve_mod_t d_next;

    // Take off one shifted multiple of 2*pi when it fits
    always_comb
    begin
        d_next = d_in;
        if ({1'b0, d_in.rem} >= modulus) begin
            d_next.rem = d_in.rem - modulus[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        d_out <= d_next;
    end

endmodule

// ----- hw/rtl/cfve_rot_cell.sv -----
`timescale 1ns / 1ps

module cfve_rot_cell (
    input  logic                 clk,
    input  logic [4:0]           shift,
    input  logic signed [43:0]   angle,
    input  cfve_pkg::cfve_rot_t  d_in,
    output cfve_pkg::cfve_rot_t  d_out
);
    import cfve_pkg::*;

    cfve_rot_t          d_next;
    logic signed [33:0] xs;
    logic signed [33:0] ys;

    // One micro-rotation toward zero residual angle
    always_comb
    begin
        xs     = d_in.x >>> shift;
        ys     = d_in.y >>> shift;
        d_next = d_in;
        if (d_in.r >= 0) begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.r = d_in.r - angle;
        end else begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.r = d_in.r + angle;
        end
    end

    always_ff @(posedge clk)
    begin
        d_out <= d_next;
    end

endmodule

// ----- hw/rtl/cfve_sincos.sv -----
`timescale 1ns / 1ps

module cfve_sincos (
    input  logic               clk,
    input  logic signed [63:0] phase,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);
    import cfve_pkg::*;

    cfve_mod_t          mod_chain [MOD_STEPS:0];
    cfve_rot_t          rot_chain [CORDIC_STAGES:0];
    cfve_mod_t          abs_next;
    logic [63:0]        red_reg;
    logic [63:0]        red_next;
    cfve_rot_t          fold_next;
    logic signed [33:0] xo;
    logic signed [33:0] yo;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_next;

    // Magnitude and sign of the phase
    always_comb
    begin
        abs_next.neg = phase[63];
        abs_next.rem = phase[63] ? 64'(-phase) : 64'(phase);
    end

    always_ff @(posedge clk)
    begin
        mod_chain[0] <= abs_next;
    end

    for (genvar j = 0; j < MOD_STEPS; j++)
    begin : g_mod
        localparam logic [64:0] MODULUS = 65'(TWO_PI_Q40) << (MOD_STEPS - 1 - j);
        cfve_mod_cell u_cell (
            .clk     (clk),
            .modulus (MODULUS),
            .d_in    (mod_chain[j]),
            .d_out   (mod_chain[j + 1])
        );
    end

    // Floor remainder in [0, 2*pi)
    always_comb
    begin
        if (mod_chain[MOD_STEPS].neg && (mod_chain[MOD_STEPS].rem != '0)) begin
            red_next = TWO_PI_Q40 - mod_chain[MOD_STEPS].rem;
        end else begin
            red_next = mod_chain[MOD_STEPS].rem;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg <= red_next;
    end

    // Fold into [-pi/2, pi/2]; wrap past pi and the half-turn fold are merged
    always_comb
    begin
        fold_next.x = CORDIC_GAIN_Q30;
        fold_next.y = '0;
        priority if (red_reg <= HALF_PI_Q40) begin
            fold_next.r    = 44'(red_reg);
            fold_next.flip = 1'b0;
        end else if (red_reg <= PI_Q40) begin
            fold_next.r    = 44'(red_reg - PI_Q40);
            fold_next.flip = 1'b1;
        end else if (red_reg < TWO_PI_Q40 - HALF_PI_Q40) begin
            fold_next.r    = 44'(red_reg - (TWO_PI_Q40 - PI_Q40));
            fold_next.flip = 1'b1;
        end else begin
            fold_next.r    = 44'(red_reg - TWO_PI_Q40);
            fold_next.flip = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_chain[0] <= fold_next;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        localparam logic signed [43:0] ANGLE = atan_q40(i);
        cfve_rot_cell u_cell (
            .clk   (clk),
            .shift (5'(i)),
            .angle (ANGLE),
            .d_in  (rot_chain[i]),
            .d_out (rot_chain[i + 1])
        );
    end

    // Undo the half-turn fold and clamp to the unit range
    always_comb
    begin
        xo = rot_chain[CORDIC_STAGES].flip ? -rot_chain[CORDIC_STAGES].x
                                           : rot_chain[CORDIC_STAGES].x;
        yo = rot_chain[CORDIC_STAGES].flip ? -rot_chain[CORDIC_STAGES].y
                                           : rot_chain[CORDIC_STAGES].y;
        priority if (xo > ONE_Q30) begin
            cos_next = 32'(ONE_Q30);
        end else if (xo < -ONE_Q30) begin
            cos_next = 32'(-ONE_Q30);
        end else begin
            cos_next = 32'(xo);
        end
        priority if (yo > ONE_Q30) begin
            sin_next = 32'(ONE_Q30);
        end else if (yo < -ONE_Q30) begin
            sin_next = 32'(-ONE_Q30);
        end else begin
            sin_next = 32'(yo);
        end
    end

    always_ff @(posedge clk)
    begin
        sin_q30 <= sin_next;
        cos_q30 <= cos_next;
    end

`ifndef SYNTH
    // The data path has no reset: skip the check until real data reaches it
    a_red_range: assert property (@(posedge clk)
        $isunknown(red_reg) || (red_reg < TWO_PI_Q40))
        else $error("reduced phase out of range");
`endif

endmodule
